[sv/arpbcm_pkg.sv]
// Shared types and constants for the ARP binding change monitor.
// No dependencies; imported by the top level, the controller and the datapath.
package arpbcm_pkg;

  localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
  localparam logic        CMD_OBSERVE   = 1'b0;
  localparam logic        CMD_PRELOAD   = 1'b1;

  localparam int IP_W   = 32;
  localparam int MAC_W  = 48;
  localparam int KIND_W = 2;

  localparam logic [KIND_W-1:0] KIND_NEW      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MODIFIED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DROPPED  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_COMPARE,
    ST_NOMATCH,
    ST_RESULT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic              load_item;
    logic              clr_idx;
    logic              inc_idx;
    logic              rd_en;
    logic              wr_hit;
    logic              wr_new;
    logic              set_pend;
    logic [KIND_W-1:0] pend_kind;
    logic              take_old;
    logic              load_out;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic relevant;
    logic fill_zero;
    logic full;
    logic hit;
    logic last;
    logic mac_diff;
    logic preload;
    logic out_free;
  } status_t;

endpackage

[sv/arp_binding_change_monitor.sv]
// Top level of the ARP binding change monitor: controller plus datapath.
// Depends on arpbcm_pkg, arpbcm_ctrl and arpbcm_datapath.
//
//   channel  handshake            payload
//   in       in_valid / in_stall  in_command, in_ether_type, in_is_outgoing,
//                                 in_sender_mac, in_sender_ip
//   out      out_valid/out_stall  out_event_kind, out_bound_ip, out_new_mac,
//                                 out_old_mac
//
// Sequence: a non-ARP or outgoing frame is dropped in its accept cycle. A
// checked beat scans the table entries up to and including the hit, or up to
// the fill count on a miss; each entry costs one RAM read (ST_ISSUE) and one
// compare (ST_COMPARE). A miss adds an insert step (ST_NOMATCH) and a result
// adds a hand-off step (ST_RESULT), which waits until the output is free.
// Reset: synchronous, active low; clears the fill count, the controller state
// and the output valid. The RAM is not cleared: only entries below the fill
// count are ever read.
// Stalls: a finished result waits in the output register while the next beat
// is accepted; a second result holds in the controller until the output frees.
module arp_binding_change_monitor
  import arpbcm_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_command,
  input  logic [15:0]       in_ether_type,
  input  logic              in_is_outgoing,
  input  logic [MAC_W-1:0]  in_sender_mac,
  input  logic [IP_W-1:0]   in_sender_ip,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [KIND_W-1:0] out_event_kind,
  output logic [IP_W-1:0]   out_bound_ip,
  output logic [MAC_W-1:0]  out_new_mac,
  output logic [MAC_W-1:0]  out_old_mac
);

  cmd_t    cmd;
  status_t status;

  // Sequence search, update and result hand-off.
  arpbcm_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .status  (status),
    .cmd     (cmd)
  );

  // Hold the table, the captured beat and the output register.
  arpbcm_datapath #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_command    (in_command),
    .in_ether_type (in_ether_type),
    .in_is_outgoing(in_is_outgoing),
    .in_sender_mac (in_sender_mac),
    .in_sender_ip  (in_sender_ip),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_event_kind(out_event_kind),
    .out_bound_ip  (out_bound_ip),
    .out_new_mac   (out_new_mac),
    .out_old_mac   (out_old_mac)
  );

endmodule

[sv/arpbcm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module arpbcm_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic                             rd_en,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[sv/arpbcm_datapath.sv]
// Datapath: captured item, search index, fill count, binding RAM, output beat.
// Depends on arpbcm_pkg and arpbcm_ram.
module arpbcm_datapath
  import arpbcm_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output status_t           status,
  input  logic              in_command,
  input  logic [15:0]       in_ether_type,
  input  logic              in_is_outgoing,
  input  logic [MAC_W-1:0]  in_sender_mac,
  input  logic [IP_W-1:0]   in_sender_ip,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [KIND_W-1:0] out_event_kind,
  output logic [IP_W-1:0]   out_bound_ip,
  output logic [MAC_W-1:0]  out_new_mac,
  output logic [MAC_W-1:0]  out_old_mac
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);
  localparam int EW = IP_W + MAC_W;

  logic              preload_r;
  logic [IP_W-1:0]   ip_r;
  logic [MAC_W-1:0]  mac_r;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic [KIND_W-1:0] pend_kind_r;
  logic [MAC_W-1:0]  pend_old_r;
  logic              out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0] out_kind_r;
  logic [IP_W-1:0]   out_ip_r;
  logic [MAC_W-1:0]  out_new_r;
  logic [MAC_W-1:0]  out_old_r;

  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic [EW-1:0]     rd_data;
  logic [IP_W-1:0]   rd_ip;
  logic [MAC_W-1:0]  rd_mac;

  assign rd_ip  = rd_data[EW-1:MAC_W];
  assign rd_mac = rd_data[MAC_W-1:0];

  assign wr_en   = cmd.wr_hit || cmd.wr_new;
  assign wr_addr = cmd.wr_hit ? idx_r : fill_r[IW-1:0];

  arpbcm_ram #(
    .WIDTH(EW),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data({ip_r, mac_r}),
    .rd_en  (cmd.rd_en),
    .rd_addr(idx_r),
    .rd_data(rd_data)
  );

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.clr_idx) begin
      idx_nxt = '0;
    end else if (cmd.inc_idx) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  assign fill_nxt = cmd.wr_new ? fill_r + 1'b1 : fill_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.load_item) begin
      preload_r <= (in_command == CMD_PRELOAD);
      ip_r      <= in_sender_ip;
      mac_r     <= in_sender_mac;
    end
    if (cmd.set_pend) begin
      pend_kind_r <= cmd.pend_kind;
      pend_old_r  <= cmd.take_old ? rd_mac : '0;
    end
    if (cmd.load_out) begin
      out_kind_r <= pend_kind_r;
      out_ip_r   <= ip_r;
      out_new_r  <= mac_r;
      out_old_r  <= pend_old_r;
    end
  end

  always_comb begin
    status.relevant  = (in_command == CMD_PRELOAD) ||
                       ((in_ether_type == ETHERTYPE_ARP) && !in_is_outgoing);
    status.fill_zero = (fill_r == '0);
    status.full      = (fill_r == FULL_COUNT);
    status.hit       = (rd_ip == ip_r);
    status.last      = ((CW'(idx_r) + 1'b1) == fill_r);
    status.mac_diff  = (rd_mac != mac_r);
    status.preload   = preload_r;
    status.out_free  = !out_valid_r || !out_stall;
  end

  assign out_valid      = out_valid_r;
  assign out_event_kind = out_kind_r;
  assign out_bound_ip   = out_ip_r;
  assign out_new_mac    = out_new_r;
  assign out_old_mac    = out_old_r;

endmodule

[sv/arpbcm_ctrl.sv]
// Controller state machine: sequences the table search, the update and the result beat.
// Depends on arpbcm_pkg.
module arpbcm_ctrl
  import arpbcm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && status.relevant) begin
          state_nxt = status.fill_zero ? ST_NOMATCH : ST_ISSUE;
        end
      end
      ST_ISSUE: state_nxt = ST_COMPARE;
      ST_COMPARE: begin
        if (status.hit) begin
          state_nxt = (!status.preload && status.mac_diff) ? ST_RESULT : ST_IDLE;
        end else if (status.last) begin
          state_nxt = ST_NOMATCH;
        end else begin
          state_nxt = ST_ISSUE;
        end
      end
      ST_NOMATCH: state_nxt = status.preload ? ST_IDLE : ST_RESULT;
      ST_RESULT: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid && status.relevant) begin
          cmd.load_item = 1'b1;
          cmd.clr_idx   = 1'b1;
        end
      end
      ST_ISSUE: cmd.rd_en = 1'b1;
      ST_COMPARE: begin
        if (status.hit) begin
          if (status.preload) begin
            cmd.wr_hit = 1'b1;
          end else if (status.mac_diff) begin
            cmd.wr_hit    = 1'b1;
            cmd.set_pend  = 1'b1;
            cmd.pend_kind = KIND_MODIFIED;
            cmd.take_old  = 1'b1;
          end
        end else if (!status.last) begin
          cmd.inc_idx = 1'b1;
        end
      end
      ST_NOMATCH: begin
        cmd.wr_new = !status.full;
        if (!status.preload) begin
          cmd.set_pend  = 1'b1;
          cmd.pend_kind = status.full ? KIND_DROPPED : KIND_NEW;
        end
      end
      ST_RESULT: cmd.load_out = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule
